[rtl/rpua_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, register codes and sine coefficients of the ring unwrap address generator.
// No dependencies.
package rpua_pkg;

    localparam int COL_W       = 15;
    localparam int ROW_W       = 12;
    localparam int OUT_W       = 15;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 32;
    localparam int M_TUSER_W   = 1;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    localparam int TWO_PI_W                = 35;
    localparam logic [TWO_PI_W-1:0] TWO_PI_Q32 = 35'd26986075409;

    localparam int Q_W                = 31;
    localparam logic [Q_W-1:0] ONE_Q30 = 31'h4000_0000;
    localparam int HORNER_STEPS       = 5;
    localparam int TRIG_LAT           = HORNER_STEPS + 4;

    typedef enum logic [2:0] {
        REG_CENTER_X     = 3'd0,
        REG_CENTER_Y     = 3'd1,
        REG_INNER_RADIUS = 3'd2,
        REG_OUTER_RADIUS = 3'd3,
        REG_IMAGE_WIDTH  = 3'd4,
        REG_IMAGE_HEIGHT = 3'd5
    } t_reg_idx;

    // Taylor terms of sin(t*pi/2) in Q30, highest order first
    function automatic logic [Q_W-1:0] sine_coef(input logic [2:0] k);
        logic [Q_W-1:0] c;
        case (k)
            3'd0:    c = 31'd3864;
            3'd1:    c = 31'd172272;
            3'd2:    c = 31'd5026996;
            3'd3:    c = 31'd85569306;
            3'd4:    c = 31'd693598668;
            3'd5:    c = 31'd1686629713;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

[rtl/ring_polar_unwrap_address_top.sv]
`timescale 1ns / 1ps
// Ring unwrap address generator: strip (col, row) to source (x, y) and in-bounds flag.
// Depends on rpua_pkg, rpua_div_cell, rpua_trig.
// An item passes the input register, a divider chain of one quotient bit per cell, the sine
// pipeline and the placement stages to the output register.
// Throughput: one item per cycle while the skid entry is empty; a two-entry output buffer keeps
// the input open while a result waits. Reset (synchronous) empties the pipeline and loads register defaults.
module ring_polar_unwrap_address_top import rpua_pkg::*; #(
    parameter int COORD_BITS     = 12,
    parameter int PHASE_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // strip_col[14:0], strip_row[26:15]
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,   // source_x[14:0], source_y[29:15]
    output logic [M_TUSER_W-1:0]  o_m_tuser,   // in_bounds[0]
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata,
    output logic                  o_pready
);

    localparam int CIRC_BITS = COORD_BITS + 3;
    localparam int R_W       = COORD_BITS + 1;
    localparam int F         = TRIG_FRAC_BITS;
    localparam int TOT_W     = COORD_BITS + F + 3;
    localparam int SX_W      = COORD_BITS + 3;
    localparam int NCELL     = COL_W + PHASE_BITS;
    localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);
    localparam logic [TOT_W-1:0] TRUNC_BIAS = (TOT_W'(1) << F) - TOT_W'(1);

    // configuration
    logic [COORD_BITS-1:0] r_cx, r_cy, r_inner, r_outer;
    logic [R_W-1:0]        r_img_w, r_img_h;
    logic [CIRC_BITS-1:0]  r_circ;
    logic [COORD_BITS+TWO_PI_W-1:0] w_circ_prod;
    logic                  w_wr;
    t_reg_idx              w_idx;

    assign o_pready    = 1'b1;
    assign w_wr        = i_psel && i_penable && i_pwrite;
    assign w_idx       = t_reg_idx'(i_paddr[APB_ADDR_W-1:2]);
    assign w_circ_prod = (COORD_BITS+TWO_PI_W)'(r_outer) * (COORD_BITS+TWO_PI_W)'(TWO_PI_Q32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx    <= '0;
            r_cy    <= '0;
            r_inner <= '0;
            r_outer <= COORD_BITS'(1);
            r_img_w <= R_W'(4096);
            r_img_h <= R_W'(4096);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_CENTER_X:     r_cx    <= i_pwdata[COORD_BITS-1:0];
                REG_CENTER_Y:     r_cy    <= i_pwdata[COORD_BITS-1:0];
                REG_INNER_RADIUS: r_inner <= i_pwdata[COORD_BITS-1:0];
                REG_OUTER_RADIUS: r_outer <= i_pwdata[COORD_BITS-1:0];
                REG_IMAGE_WIDTH:  r_img_w <= i_pwdata[R_W-1:0];
                REG_IMAGE_HEIGHT: r_img_h <= i_pwdata[R_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_circ <= w_circ_prod[COORD_BITS+TWO_PI_W-1:32];
    end

    always_comb begin
        unique case (w_idx)
            REG_CENTER_X:     o_prdata = APB_DATA_W'(r_cx);
            REG_CENTER_Y:     o_prdata = APB_DATA_W'(r_cy);
            REG_INNER_RADIUS: o_prdata = APB_DATA_W'(r_inner);
            REG_OUTER_RADIUS: o_prdata = APB_DATA_W'(r_outer);
            REG_IMAGE_WIDTH:  o_prdata = APB_DATA_W'(r_img_w);
            REG_IMAGE_HEIGHT: o_prdata = APB_DATA_W'(r_img_h);
            default:          o_prdata = '0;
        endcase
    end

    // pipeline control
    logic r_skid_valid;
    logic w_en;
    assign w_en       = !r_skid_valid;
    assign o_s_tready = w_en;

    // input stage
    logic             r_in_valid;
    logic [COL_W-1:0] r_in_col;
    logic [ROW_W-1:0] r_in_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_en) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_col <= i_s_tdata[COL_W-1:0];
            r_in_row <= i_s_tdata[COL_W+ROW_W-1:COL_W];
        end
    end

    // divider chain
    logic                  w_valid [NCELL+1];
    logic [COL_W-1:0]      w_col   [NCELL+1];
    logic [CIRC_BITS-1:0]  w_rem   [NCELL+1];
    logic [PHASE_BITS-1:0] w_quo   [NCELL+1];
    logic [ROW_W-1:0]      w_row   [NCELL+1];

    assign w_valid[0] = r_in_valid;
    assign w_col[0]   = r_in_col;
    assign w_rem[0]   = '0;
    assign w_quo[0]   = '0;
    assign w_row[0]   = r_in_row;

    for (genvar c = 0; c < NCELL; c++) begin : g_cell
        rpua_div_cell #(
            .CIRC_BITS  (CIRC_BITS),
            .PHASE_BITS (PHASE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_circ  (r_circ),
            .i_valid (w_valid[c]),
            .i_col   (w_col[c]),
            .i_rem   (w_rem[c]),
            .i_quo   (w_quo[c]),
            .i_row   (w_row[c]),
            .o_valid (w_valid[c+1]),
            .o_col   (w_col[c+1]),
            .o_rem   (w_rem[c+1]),
            .o_quo   (w_quo[c+1]),
            .o_row   (w_row[c+1])
        );
    end

    // phase and radius
    logic [PHASE_BITS-1:0] w_phase, w_cphase;
    logic [R_W-1:0]        w_radius;

    assign w_phase  = (r_circ == '0) ? '0 : w_quo[NCELL];
    assign w_cphase = w_phase + QUARTER;
    assign w_radius = R_W'(r_inner) + R_W'(w_row[NCELL]);

    logic signed [F:0] w_sin, w_cos;

    rpua_trig #(
        .PHASE_BITS     (PHASE_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_sin (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (w_phase),
        .o_trig  (w_sin)
    );

    rpua_trig #(
        .PHASE_BITS     (PHASE_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_cos (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (w_cphase),
        .o_trig  (w_cos)
    );

    // valid and radius alongside the sine pipeline
    logic           r_tv [TRIG_LAT];
    logic [R_W-1:0] r_tr [TRIG_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TRIG_LAT; k++) begin
                r_tv[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_tv[0] <= w_valid[NCELL];
            for (int k = 1; k < TRIG_LAT; k++) begin
                r_tv[k] <= r_tv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tr[0] <= w_radius;
            for (int k = 1; k < TRIG_LAT; k++) begin
                r_tr[k] <= r_tr[k-1];
            end
        end
    end

    // placement: products, sums, truncation, bounds
    logic                    r_p1_valid, r_p2_valid, r_p3_valid, r_p4_valid;
    logic signed [TOT_W-1:0] r_p1_x, r_p1_y, r_p2_x, r_p2_y;
    logic signed [SX_W-1:0]  r_p3_x, r_p3_y;
    logic [OUT_W-1:0]        r_p4_x, r_p4_y;
    logic                    r_p4_inb;

    logic [TOT_W-1:0]        w_bx, w_by;
    logic                    w_inb;

    assign w_bx  = r_p2_x + (r_p2_x[TOT_W-1] ? TRUNC_BIAS : '0);
    assign w_by  = r_p2_y + (r_p2_y[TOT_W-1] ? TRUNC_BIAS : '0);
    assign w_inb = !r_p3_x[SX_W-1] && !r_p3_y[SX_W-1]
                && (r_p3_x[SX_W-2:0] < (SX_W-1)'(r_img_w))
                && (r_p3_y[SX_W-2:0] < (SX_W-1)'(r_img_h));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
            r_p4_valid <= 1'b0;
        end else if (w_en) begin
            r_p1_valid <= r_tv[TRIG_LAT-1];
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
            r_p4_valid <= r_p3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_x   <= TOT_W'($signed({1'b0, r_tr[TRIG_LAT-1]})) * TOT_W'(w_cos);
            r_p1_y   <= TOT_W'($signed({1'b0, r_tr[TRIG_LAT-1]})) * TOT_W'(w_sin);
            r_p2_x   <= r_p1_x + TOT_W'($signed({1'b0, r_cx, {F{1'b0}}}));
            r_p2_y   <= r_p1_y + TOT_W'($signed({1'b0, r_cy, {F{1'b0}}}));
            r_p3_x   <= w_bx[TOT_W-1:F];
            r_p3_y   <= w_by[TOT_W-1:F];
            r_p4_x   <= OUT_W'(r_p3_x);
            r_p4_y   <= OUT_W'(r_p3_y);
            r_p4_inb <= w_inb;
        end
    end

    // output register and skid entry
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_x, r_out_y, r_skid_x, r_skid_y;
    logic             r_out_inb, r_skid_inb;
    logic             w_push, w_pop;

    assign w_push = w_en && r_p4_valid;
    assign w_pop  = r_out_valid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_valid || w_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out_x   <= r_skid_x;
                r_out_y   <= r_skid_y;
                r_out_inb <= r_skid_inb;
            end
        end else if (w_push) begin
            if (!r_out_valid || w_pop) begin
                r_out_x   <= r_p4_x;
                r_out_y   <= r_p4_y;
                r_out_inb <= r_p4_inb;
            end else begin
                r_skid_x   <= r_p4_x;
                r_skid_y   <= r_p4_y;
                r_skid_inb <= r_p4_inb;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'({r_out_y, r_out_x});
    assign o_m_tuser  = r_out_inb;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds an item while output register is empty");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_m_tready) |=> (o_m_tvalid && !r_skid_valid))
        else $error("skid entry did not move to output register");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p4_valid && r_skid_valid) |=> r_p4_valid)
        else $error("last pipeline item lost during stall");

endmodule

[rtl/rpua_div_cell.sv]
`timescale 1ns / 1ps
// One restoring-division cell: one quotient bit of column * 2^PHASE_BITS / circumference.
// Depends on rpua_pkg.
module rpua_div_cell import rpua_pkg::*; #(
    parameter int CIRC_BITS  = 15,
    parameter int PHASE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [CIRC_BITS-1:0]  i_circ,
    input  logic                  i_valid,
    input  logic [COL_W-1:0]      i_col,
    input  logic [CIRC_BITS-1:0]  i_rem,
    input  logic [PHASE_BITS-1:0] i_quo,
    input  logic [ROW_W-1:0]      i_row,
    output logic                  o_valid,
    output logic [COL_W-1:0]      o_col,
    output logic [CIRC_BITS-1:0]  o_rem,
    output logic [PHASE_BITS-1:0] o_quo,
    output logic [ROW_W-1:0]      o_row
);

    logic                  r_valid;
    logic [COL_W-1:0]      r_col;
    logic [CIRC_BITS-1:0]  r_rem;
    logic [PHASE_BITS-1:0] r_quo;
    logic [ROW_W-1:0]      r_row;

    logic [CIRC_BITS:0] w_trial;
    logic [CIRC_BITS:0] w_diff;
    logic               w_ge;

    assign w_trial = {i_rem, i_col[COL_W-1]};
    assign w_diff  = w_trial - {1'b0, i_circ};
    assign w_ge    = w_trial >= {1'b0, i_circ};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= w_ge ? w_diff[CIRC_BITS-1:0] : w_trial[CIRC_BITS-1:0];
            r_quo <= {i_quo[PHASE_BITS-2:0], w_ge};
            r_col <= {i_col[COL_W-2:0], 1'b0};
            r_row <= i_row;
        end
    end

    assign o_valid = r_valid;
    assign o_col   = r_col;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_row   = r_row;

endmodule

[rtl/rpua_trig.sv]
`timescale 1ns / 1ps
// Pipelined fixed-point sine of a phase: quadrant fold, degree-11 odd polynomial, rounding.
// Depends on rpua_pkg.
module rpua_trig import rpua_pkg::*; #(
    parameter int PHASE_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [PHASE_BITS-1:0]          i_phase,
    output logic signed [TRIG_FRAC_BITS:0] o_trig
);

    localparam int QB   = PHASE_BITS - 2;
    localparam int LAST = HORNER_STEPS + 1;
    localparam int F    = TRIG_FRAC_BITS;
    localparam logic [31:0] RND = 32'(1) << (29 - F);

    logic [1:0]     r_q  [LAST+1];
    logic [Q_W-1:0] r_t  [LAST+1];
    logic [Q_W-1:0] r_t2 [1:LAST];
    logic [Q_W-1:0] r_a  [1:LAST];

    logic [Q_W-1:0]     r_m;
    logic [1:0]         r_mq;
    logic signed [F:0]  r_out;

    logic [Q_W-1:0]     w_t_raw;
    logic [2*Q_W-1:0]   w_tt;
    logic [2*Q_W-1:0]   w_ta;
    logic [31:0]        w_rnd;
    logic [F+1:0]       w_mag_full;
    logic [F-1:0]       w_mag;

    assign w_t_raw = Q_W'({i_phase[QB-1:0], {(30-QB){1'b0}}});
    assign w_tt    = (2*Q_W)'(r_t[0]) * (2*Q_W)'(r_t[0]);
    assign w_ta    = (2*Q_W)'(r_t[LAST]) * (2*Q_W)'(r_a[LAST]);
    assign w_rnd   = {1'b0, r_m} + RND;
    assign w_mag_full = w_rnd[31:30-F];
    assign w_mag   = (w_mag_full[F+1:F] != 2'b00) ? {F{1'b1}} : w_mag_full[F-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0]  <= i_phase[PHASE_BITS-1:PHASE_BITS-2];
            r_t[0]  <= i_phase[PHASE_BITS-2] ? (ONE_Q30 - w_t_raw) : w_t_raw;
            r_q[1]  <= r_q[0];
            r_t[1]  <= r_t[0];
            r_t2[1] <= w_tt[Q_W+29:30];
            r_a[1]  <= sine_coef(3'd0);
            r_m     <= w_ta[Q_W+29:30];
            r_mq    <= r_q[LAST];
            r_out   <= r_mq[1] ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
        end
    end

    for (genvar k = 2; k <= LAST; k++) begin : g_horner
        logic [2*Q_W-1:0] w_prod;
        logic [31:0]      w_next;
        assign w_prod = (2*Q_W)'(r_t2[k-1]) * (2*Q_W)'(r_a[k-1]);
        assign w_next = {1'b0, sine_coef(3'(k-1))} - w_prod[61:30];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[k]  <= w_next[Q_W-1:0];
                r_t2[k] <= r_t2[k-1];
                r_t[k]  <= r_t[k-1];
                r_q[k]  <= r_q[k-1];
            end
        end
    end

    assign o_trig = r_out;

endmodule
